// ----- sv/drt_pkg.sv -----
// Package for the debounced input relay timer.
// Holds the shared types, register codes and prescaler constants; no dependencies.
package drt_pkg;

  localparam int CHANNELS        = 4;
  localparam int TICKS_PER_STEP  = 5;
  localparam int STEPS_PER_DIV   = 10;
  localparam int DIVS_PER_SECOND = 10;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE_COUNT = 4'd0,
    REG_DOOR_HOLD      = 4'd1,
    REG_LIGHT_HOLD     = 4'd2,
    REG_ACTIVE_LEVEL   = 4'd3
  } cfg_reg_t;

  // Control shared by the per-input debouncers.
  typedef struct packed {
    logic advance;    // a transaction moves through the update stage
    logic step;       // this tick completes a 10 ms step
    logic hold;       // startup hold after this tick
    logic level_off;  // inactive level
  } drt_ctrl_t;

  typedef struct packed {
    logic [CHANNELS-1:0] relay_outputs;
    logic [CHANNELS-1:0] debounced_inputs;
    logic                second_pulse;
    logic                in_startup;
  } drt_result_t;

endpackage

// ----- sv/drt_if.sv -----
// Handshake channel interfaces for the debounced input relay timer.
// Depends on drt_pkg for the channel count.
interface drt_in_if import drt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CHANNELS-1:0] raw_inputs;

  modport source (output valid, output raw_inputs, input ready);
  modport sink (input valid, input raw_inputs, output ready);
endinterface

interface drt_out_if import drt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CHANNELS-1:0] relay_outputs;
  logic [CHANNELS-1:0] debounced_inputs;
  logic                second_pulse;
  logic                in_startup;

  modport source (output valid, output relay_outputs, output debounced_inputs,
                  output second_pulse, output in_startup, input ready);
  modport sink (input valid, input relay_outputs, input debounced_inputs,
                input second_pulse, input in_startup, output ready);
endinterface

// ----- sv/debounced_input_relay_timer.sv -----
// Debounced input relay timer: prescaler, four debouncers and four relay timers.
// Depends on drt_pkg, drt_if and drt_debounce.
//
// Usage: each transaction on in_ch is one 2 ms tick carrying four raw input
// levels; each yields exactly one transaction on out_ch with the relay bits,
// debounced levels, a one-second pulse flag and the startup flag.
// Five ticks make a 10 ms debounce step, 100 steps make one second, on which
// nonzero relay timers count down. An active debounced input reloads its
// timers with the door or light hold time. Until the first second the inputs
// are held inactive and the timers at zero.
// The result is registered: the input register takes the tick, then the update
// stage writes the result register, and an out_ch stall can come between them.
// Throughput: one tick per cycle while out_ch does not stall.
// Reset (rst_n low, synchronous) clears both stages, the prescaler, debouncers
// and timers, and loads the register defaults (5, 5, 30, active low).
// When out_ch stalls, the result holds and one more tick waits in the input
// register; in_ch.ready drops only when both are full.
// Configuration: cfg_we, cfg_index, cfg_wdata; write only while idle.
module debounced_input_relay_timer import drt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  drt_in_if.sink                in_ch,
  drt_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // configuration registers
  logic [7:0] debounce_count_r;
  logic [7:0] door_hold_r;
  logic [7:0] light_hold_r;
  logic       active_level_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_count_r <= 8'd5;
      door_hold_r      <= 8'd5;
      light_hold_r     <= 8'd30;
      active_level_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DEBOUNCE_COUNT: debounce_count_r <= cfg_wdata[7:0];
        REG_DOOR_HOLD:      door_hold_r      <= cfg_wdata[7:0];
        REG_LIGHT_HOLD:     light_hold_r     <= cfg_wdata[7:0];
        REG_ACTIVE_LEVEL:   active_level_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // input register and output register handshake
  logic                s1_valid_r;
  logic [CHANNELS-1:0] s1_raw_r;
  logic                out_valid_r;
  drt_result_t         out_r;
  drt_result_t         out_nxt;
  logic                advance;

  assign advance     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_raw_r <= in_ch.raw_inputs;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= out_nxt;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.relay_outputs    = out_r.relay_outputs;
  assign out_ch.debounced_inputs = out_r.debounced_inputs;
  assign out_ch.second_pulse     = out_r.second_pulse;
  assign out_ch.in_startup       = out_r.in_startup;

  // prescaler
  logic [2:0] tick_r, tick_nxt, tick_inc;
  logic [3:0] ten_r, ten_nxt, ten_inc;
  logic [3:0] hundred_r, hundred_nxt, hundred_inc;
  logic       hold_r, hold_nxt;
  logic       step, div, pulse;

  assign tick_inc    = tick_r + 3'd1;
  assign ten_inc     = ten_r + 4'd1;
  assign hundred_inc = hundred_r + 4'd1;
  assign step        = (tick_inc == 3'(TICKS_PER_STEP));
  assign div         = step && (ten_inc == 4'(STEPS_PER_DIV));
  assign pulse       = div && (hundred_inc == 4'(DIVS_PER_SECOND));
  assign hold_nxt    = hold_r && !pulse;

  // debouncers
  drt_ctrl_t           ctrl;
  logic [CHANNELS-1:0] stable_nxt;
  logic [CHANNELS-1:0] act;

  assign ctrl.advance   = advance;
  assign ctrl.step      = step;
  assign ctrl.hold      = hold_nxt;
  assign ctrl.level_off = !active_level_r;

  for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_dbn
    drt_debounce u_dbn (
      .clk            (clk),
      .rst_n          (rst_n),
      .ctrl           (ctrl),
      .sample         (s1_raw_r[ch]),
      .debounce_count (debounce_count_r),
      .stable_nxt     (stable_nxt[ch])
    );
  end

  assign act = hold_nxt ? '0 : ~(stable_nxt ^ {CHANNELS{active_level_r}});

  // relay timers
  logic [7:0] timer_r   [CHANNELS];
  logic [7:0] timer_nxt [CHANNELS];
  logic [7:0] timer_dec [CHANNELS];

  always_comb begin
    for (int ch = 0; ch < CHANNELS; ch++) begin
      timer_dec[ch] = (pulse && timer_r[ch] != 8'd0) ? timer_r[ch] - 8'd1 : timer_r[ch];
    end
    timer_nxt[0] = act[0] ? door_hold_r : timer_dec[0];
    timer_nxt[1] = act[1] ? door_hold_r : timer_dec[1];
    timer_nxt[2] = act[2] ? door_hold_r : timer_dec[2];
    timer_nxt[3] = (act[0] || act[1] || act[3]) ? light_hold_r : timer_dec[3];
    if (hold_nxt) begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
        timer_nxt[ch] = '0;
      end
    end
  end

  always_comb begin
    tick_nxt    = step ? 3'd0 : tick_inc;
    ten_nxt     = step ? (div ? 4'd0 : ten_inc) : ten_r;
    hundred_nxt = div ? (pulse ? 4'd0 : hundred_inc) : hundred_r;
    // any active input restarts the current second
    if (|act) begin
      hundred_nxt = '0;
    end
  end

  always_comb begin
    for (int ch = 0; ch < CHANNELS; ch++) begin
      out_nxt.relay_outputs[ch] = (timer_nxt[ch] != 8'd0);
    end
    out_nxt.debounced_inputs = stable_nxt;
    out_nxt.second_pulse     = pulse;
    out_nxt.in_startup       = hold_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r    <= '0;
      ten_r     <= '0;
      hundred_r <= '0;
      hold_r    <= 1'b1;
      for (int ch = 0; ch < CHANNELS; ch++) begin
        timer_r[ch] <= '0;
      end
    end else if (advance) begin
      tick_r    <= tick_nxt;
      ten_r     <= ten_nxt;
      hundred_r <= hundred_nxt;
      hold_r    <= hold_nxt;
      for (int ch = 0; ch < CHANNELS; ch++) begin
        timer_r[ch] <= timer_nxt[ch];
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_startup_relays_off: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.in_startup) |-> (out_ch.relay_outputs == '0))
    else $error("relay driven during startup hold");

  a_pulse_ends_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.second_pulse) |-> !out_ch.in_startup)
    else $error("startup flag set on a second pulse");

  a_hold_stays_off: assert property (@(posedge clk) disable iff (!rst_n)
    !hold_r |=> !hold_r)
    else $error("startup hold set again after release");

  a_empty_stage_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_ch.ready)
    else $error("input stalled with empty input register");
`endif

endmodule

// ----- sv/drt_debounce.sv -----
// Counter debouncer for one input of the relay timer.
// Depends on drt_pkg for the control struct.
module drt_debounce import drt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  drt_ctrl_t  ctrl,
  input  logic       sample,
  input  logic [7:0] debounce_count,
  output logic       stable_nxt
);

  logic [7:0] count_r;
  logic [7:0] count_nxt;
  logic [7:0] count_inc;
  logic       stable_r;
  logic       level_dbn;

  assign count_inc = count_r + 8'd1;

  always_comb begin
    count_nxt = count_r;
    level_dbn = stable_r;
    if (ctrl.step) begin
      if (sample != stable_r) begin
        if (count_inc >= debounce_count) begin
          count_nxt = '0;
          level_dbn = sample;
        end else begin
          count_nxt = count_inc;
        end
      end else begin
        count_nxt = '0;
      end
    end
    // force inactive while the startup hold lasts; the counter keeps running
    stable_nxt = ctrl.hold ? ctrl.level_off : level_dbn;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      stable_r <= 1'b1;
    end else if (ctrl.advance) begin
      count_r  <= count_nxt;
      stable_r <= stable_nxt;
    end
  end

endmodule
